/* rtl/pid_integral_separation_top_assert.svh */
// Assertion macros for the PID integral separation block.
`ifndef PID_INTEGRAL_SEPARATION_TOP_ASSERT_SVH
`define PID_INTEGRAL_SEPARATION_TOP_ASSERT_SVH

// Check cons at the same edge as ante.
`define PIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons at the edge after ante.
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pis_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int RATE_W     = 16;
  localparam int LIM_W      = 31;
  localparam int CFG_IDX_W  = 3;

  localparam int ERR_W      = DATA_W + 1;
  localparam int FSUM_W     = DATA_W + 3;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int MUL_A_W    = TERM_W + 1;
  localparam int MUL_B_W    = FRAC_BITS + 1;
  localparam int ACC_W      = MUL_A_W + MUL_B_W;
  localparam int ISUM_W     = TERM_W + 2;

  localparam int DIV_W      = TERM_W;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [RATE_W-1:0] RATE_RST = 16'd1000;
  localparam logic [LIM_W-1:0]  LIM_RST  = 31'h7FFF_FFFF;
  localparam logic [RATE_W-1:0] FILT_DEN = 16'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BAND   = 3'd6;

endpackage
`default_nettype wire

/* rtl/pis_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface pis_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pis_pkg::DATA_W-1:0]   measured;
  logic signed [pis_pkg::DATA_W-1:0]   setpoint;
  logic signed [pis_pkg::DATA_W-1:0]   feedforward;

  modport source (output valid, measured, setpoint, feedforward, input ready);
  modport sink (input valid, measured, setpoint, feedforward, output ready);
endinterface

interface pis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pis_pkg::DATA_W-1:0]   drive;
  logic                                integrating;

  modport source (output valid, drive, integrating, input ready);
  modport sink (input valid, drive, integrating, output ready);
endinterface
`default_nettype wire

/* rtl/pid_integral_separation_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// PID controller with integral separation, signed Q16.16 throughout.
// in_ch carries one request: measured, setpoint, feedforward. out_ch returns
// one result per request: the clamped drive and the integrating flag.
// cfg_we/cfg_idx/cfg_wdata write the gain, rate and limit registers; write
// them only while no request is in flight.
// Each request runs on one 49x17 multiplier (two passes per gain product)
// and one divider retiring 4 quotient bits per cycle. The integrator
// division runs only when the error lies in the separation band.
// in_ch.ready is high only while the sequencer is idle, so a new request
// is taken only after the previous one has left the sequencer.
// The result sits in an output register; a new request is taken while it
// waits. If out_ch stalls, the next result holds in the final step until the
// register frees, and no further request is taken meanwhile.
// Synchronous reset clears the filter and integrator, loads register reset
// values (rate 1000, limits at full scale) and empties the output.
module pid_integral_separation_top (
  input  wire                             clk,
  input  wire                             rst_n,
  pis_in_if.sink                          in_ch,
  pis_out_if.source                       out_ch,
  input  wire                             cfg_we,
  input  wire [pis_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [pis_pkg::DATA_W-1:0]       cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MLO   = 4'd1;
  localparam logic [3:0] S_MHI   = 4'd2;
  localparam logic [3:0] S_MACC  = 4'd3;
  localparam logic [3:0] S_MDONE = 4'd4;
  localparam logic [3:0] S_IDIV  = 4'd5;
  localparam logic [3:0] S_IUPD  = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_FUPD  = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_CLAMP = 4'd10;

  localparam logic [1:0] OP_P = 2'd0;
  localparam logic [1:0] OP_D = 2'd1;
  localparam logic [1:0] OP_R = 2'd2;
  localparam logic [1:0] OP_I = 2'd3;

  localparam int DW  = pis_pkg::DATA_W;
  localparam int AW  = pis_pkg::ACC_W;
  localparam int QW  = pis_pkg::DIV_W;
  localparam int RW  = pis_pkg::RATE_W;
  localparam int LW  = pis_pkg::LIM_W;
  localparam int FB  = pis_pkg::FRAC_BITS;
  localparam int PW  = pis_pkg::PROD_W;
  localparam int TW  = pis_pkg::TERM_W;
  localparam int EW  = pis_pkg::ERR_W;
  localparam int SW  = pis_pkg::FSUM_W;
  localparam int IW  = pis_pkg::ISUM_W;
  localparam int MAW = pis_pkg::MUL_A_W;
  localparam int MBW = pis_pkg::MUL_B_W;
  localparam int CW  = pis_pkg::DIV_CNT_W;

  function automatic logic signed [AW-1:0] sat_sym(input logic signed [AW-1:0] x,
                                                   input logic [LW-1:0] lim);
    logic signed [AW-1:0] hi;
    hi = $signed({{(AW-LW){1'b0}}, lim});
    if (x > hi) sat_sym = hi;
    else if (x < -hi) sat_sym = -hi;
    else sat_sym = x;
  endfunction

  // control
  logic [3:0]            state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [CW-1:0]         dv_cnt_r, dv_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // configuration and loop state
  logic signed [DW-1:0]  kp_r, kp_nxt, ki_r, ki_nxt, kd_r, kd_nxt;
  logic [RW-1:0]         rate_r, rate_nxt;
  logic [LW-1:0]         olim_r, olim_nxt, ilim_r, ilim_nxt, band_r, band_nxt;
  logic signed [DW-1:0]  filt_r, filt_nxt, integ_r, integ_nxt;

  // request payload and intermediate terms
  logic signed [EW-1:0]  err_r, err_nxt, diff_r, diff_nxt;
  logic signed [DW-1:0]  ff_r, ff_nxt;
  logic                  hit_r, hit_nxt, fneg_r, fneg_nxt, ineg_r, ineg_nxt;
  logic [SW-1:0]         fdd_r, fdd_nxt;
  logic signed [AW-1:0]  pp_r, pp_nxt, acc_r, acc_nxt, tot_r, tot_nxt;
  logic signed [TW-1:0]  p_r, p_nxt, t_r, t_nxt;
  logic signed [PW-1:0]  d_r, d_nxt;
  logic [QW-1:0]         dv_quo_r, dv_quo_nxt;
  logic [RW-1:0]         dv_rem_r, dv_rem_nxt, dv_den_r, dv_den_nxt;
  logic signed [DW-1:0]  out_drive_r, out_drive_nxt;
  logic                  out_integ_r, out_integ_nxt;

  // combinational helpers
  logic [RW-1:0]         rate_eff;
  logic signed [EW-1:0]  err_in, diff_in;
  logic [EW-1:0]         aerr_in;
  logic signed [SW-1:0]  fsum_in;
  logic signed [DW-1:0]  gain;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [AW-1:0]  mul_p;
  logic [QW-1:0]         step_quo;
  logic [RW-1:0]         step_rem;
  logic signed [AW-1:0]  imag;
  logic signed [IW-1:0]  q_s, inc, isum;
  logic signed [AW-1:0]  isat, ffsat, totsat;
  logic signed [QW:0]    fq, fval;

  assign rate_eff = (rate_r == '0) ? RW'(1) : rate_r;

  assign err_in  = EW'(in_ch.setpoint) - EW'(in_ch.measured);
  assign diff_in = EW'(in_ch.measured) - EW'(filt_r);
  assign aerr_in = err_in[EW-1] ? EW'(-err_in) : EW'(err_in);
  assign fsum_in = (SW'(filt_r) <<< 2) + SW'(in_ch.measured);

  // shared multiplier operands
  always_comb begin
    case (op_r)
      OP_P:    gain = kp_r;
      OP_I:    gain = ki_r;
      default: gain = kd_r;
    endcase
    case (op_r)
      OP_D:    mul_a = MAW'(diff_r);
      OP_R:    mul_a = MAW'(t_r);
      default: mul_a = MAW'(err_r);
    endcase
    if (state_r == S_MLO) begin
      mul_b = (op_r == OP_R) ? $signed({1'b0, rate_eff}) : $signed({1'b0, gain[FB-1:0]});
    end else begin
      mul_b = (op_r == OP_R) ? '0 : $signed({gain[DW-1], gain[DW-1:FB]});
    end
  end

  assign mul_p = AW'(mul_a) * AW'(mul_b);

  // divider: retire DIV_STEP quotient bits per cycle
  always_comb begin
    logic [RW:0] trial;
    step_quo = dv_quo_r;
    step_rem = dv_rem_r;
    for (int i = 0; i < pis_pkg::DIV_STEP; i++) begin
      trial    = {step_rem, step_quo[QW-1]};
      step_quo = {step_quo[QW-2:0], 1'b0};
      if (trial >= {1'b0, dv_den_r}) begin
        step_rem    = RW'(trial - {1'b0, dv_den_r});
        step_quo[0] = 1'b1;
      end else begin
        step_rem = trial[RW-1:0];
      end
    end
  end

  assign imag   = acc_r[AW-1] ? -acc_r : acc_r;
  assign q_s    = $signed({2'b00, dv_quo_r});
  assign inc    = ineg_r ? -q_s : q_s;
  assign isum   = IW'(integ_r) + inc;
  assign isat   = sat_sym(AW'(isum), ilim_r);
  assign ffsat  = sat_sym(AW'(ff_r), olim_r);
  assign totsat = sat_sym(tot_r, olim_r);
  assign fq     = $signed({1'b0, dv_quo_r});
  assign fval   = fneg_r ? -fq : fq;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dv_cnt_nxt    = dv_cnt_r;
    out_valid_nxt = out_valid_r;
    kp_nxt        = kp_r;
    ki_nxt        = ki_r;
    kd_nxt        = kd_r;
    rate_nxt      = rate_r;
    olim_nxt      = olim_r;
    ilim_nxt      = ilim_r;
    band_nxt      = band_r;
    filt_nxt      = filt_r;
    integ_nxt     = integ_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    ff_nxt        = ff_r;
    hit_nxt       = hit_r;
    fneg_nxt      = fneg_r;
    ineg_nxt      = ineg_r;
    fdd_nxt       = fdd_r;
    pp_nxt        = pp_r;
    acc_nxt       = acc_r;
    tot_nxt       = tot_r;
    p_nxt         = p_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    dv_quo_nxt    = dv_quo_r;
    dv_rem_nxt    = dv_rem_r;
    dv_den_nxt    = dv_den_r;
    out_drive_nxt = out_drive_r;
    out_integ_nxt = out_integ_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        pis_pkg::REG_PROP_GAIN:  kp_nxt   = $signed(cfg_wdata);
        pis_pkg::REG_INTEG_GAIN: ki_nxt   = $signed(cfg_wdata);
        pis_pkg::REG_DERIV_GAIN: kd_nxt   = $signed(cfg_wdata);
        pis_pkg::REG_RATE:       rate_nxt = cfg_wdata[RW-1:0];
        pis_pkg::REG_OUT_LIMIT:  olim_nxt = cfg_wdata[LW-1:0];
        pis_pkg::REG_INT_LIMIT:  ilim_nxt = cfg_wdata[LW-1:0];
        pis_pkg::REG_SEP_BAND:   band_nxt = cfg_wdata[LW-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          err_nxt   = err_in;
          diff_nxt  = diff_in;
          ff_nxt    = in_ch.feedforward;
          hit_nxt   = aerr_in < {{(EW-LW){1'b0}}, band_r};
          fneg_nxt  = fsum_in[SW-1];
          // floor division of a negative sum: divide (|s| + 4) and negate
          fdd_nxt   = fsum_in[SW-1] ? SW'(-fsum_in + SW'(4)) : SW'(fsum_in);
          op_nxt    = OP_P;
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        pp_nxt    = mul_p;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        acc_nxt   = pp_r;
        pp_nxt    = mul_p;
        state_nxt = S_MACC;
      end
      S_MACC: begin
        acc_nxt   = acc_r + (pp_r <<< FB);
        state_nxt = S_MDONE;
      end
      S_MDONE: begin
        case (op_r)
          OP_P: begin
            p_nxt     = acc_r[PW-1:FB];
            op_nxt    = OP_D;
            state_nxt = S_MLO;
          end
          OP_D: begin
            t_nxt     = acc_r[PW-1:FB];
            op_nxt    = OP_R;
            state_nxt = S_MLO;
          end
          OP_R: begin
            d_nxt = acc_r[PW-1:0];
            if (hit_r) begin
              op_nxt    = OP_I;
              state_nxt = S_MLO;
            end else begin
              // outside the band: drop the integrator, go straight to the filter
              integ_nxt  = '0;
              dv_quo_nxt = {{(QW-SW){1'b0}}, fdd_r};
              dv_rem_nxt = '0;
              dv_den_nxt = pis_pkg::FILT_DEN;
              dv_cnt_nxt = '0;
              state_nxt  = S_FDIV;
            end
          end
          default: begin
            ineg_nxt   = acc_r[AW-1];
            dv_quo_nxt = imag[PW-1:FB];
            dv_rem_nxt = '0;
            dv_den_nxt = rate_eff;
            dv_cnt_nxt = '0;
            state_nxt  = S_IDIV;
          end
        endcase
      end
      S_IDIV: begin
        dv_quo_nxt = step_quo;
        dv_rem_nxt = step_rem;
        dv_cnt_nxt = dv_cnt_r + CW'(1);
        if (dv_cnt_r == CW'(pis_pkg::DIV_CYCLES - 1)) begin
          state_nxt = S_IUPD;
        end
      end
      S_IUPD: begin
        integ_nxt  = isat[DW-1:0];
        dv_quo_nxt = {{(QW-SW){1'b0}}, fdd_r};
        dv_rem_nxt = '0;
        dv_den_nxt = pis_pkg::FILT_DEN;
        dv_cnt_nxt = '0;
        state_nxt  = S_FDIV;
      end
      S_FDIV: begin
        dv_quo_nxt = step_quo;
        dv_rem_nxt = step_rem;
        dv_cnt_nxt = dv_cnt_r + CW'(1);
        if (dv_cnt_r == CW'(pis_pkg::DIV_CYCLES - 1)) begin
          state_nxt = S_FUPD;
        end
      end
      S_FUPD: begin
        filt_nxt  = fval[DW-1:0];
        ff_nxt    = ffsat[DW-1:0];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        tot_nxt   = AW'(p_r) + AW'(d_r) + AW'(integ_r) + AW'(ff_r);
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = totsat[DW-1:0];
          out_integ_nxt = hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P;
      dv_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      rate_r      <= pis_pkg::RATE_RST;
      olim_r      <= pis_pkg::LIM_RST;
      ilim_r      <= pis_pkg::LIM_RST;
      band_r      <= '0;
      filt_r      <= '0;
      integ_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      dv_cnt_r    <= dv_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      rate_r      <= rate_nxt;
      olim_r      <= olim_nxt;
      ilim_r      <= ilim_nxt;
      band_r      <= band_nxt;
      filt_r      <= filt_nxt;
      integ_r     <= integ_nxt;
    end
    err_r       <= err_nxt;
    diff_r      <= diff_nxt;
    ff_r        <= ff_nxt;
    hit_r       <= hit_nxt;
    fneg_r      <= fneg_nxt;
    ineg_r      <= ineg_nxt;
    fdd_r       <= fdd_nxt;
    pp_r        <= pp_nxt;
    acc_r       <= acc_nxt;
    tot_r       <= tot_nxt;
    p_r         <= p_nxt;
    t_r         <= t_nxt;
    d_r         <= d_nxt;
    dv_quo_r    <= dv_quo_nxt;
    dv_rem_r    <= dv_rem_nxt;
    dv_den_r    <= dv_den_nxt;
    out_drive_r <= out_drive_nxt;
    out_integ_r <= out_integ_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive       = out_drive_r;
  assign out_ch.integrating = out_integ_r;

endmodule
`default_nettype wire

/* rtl/pis_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "pid_integral_separation_top_assert.svh"
module pis_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [pis_pkg::DATA_W-1:0]    out_drive,
  input wire                          out_integrating
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count requests taken but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 2'd1;
    else if (!in_acc && out_acc) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PIS_ASSERT_NEXT(a_busy_after_req, in_acc, !in_ready, "request taken while one is in work")
  `PIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive) && $stable(out_integrating), "stalled result changed")
  `PIS_ASSERT_SAME(a_out_has_req, out_acc, pend_r != 2'd0, "result without a request")
  `PIS_ASSERT_SAME(a_in_room, in_acc, pend_r != 2'd2 && pend_r != 2'd3, "request taken with no room")

endmodule

bind pid_integral_separation_top pis_checker u_pis_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_drive       (out_ch.drive),
  .out_integrating (out_ch.integrating)
);
`default_nettype wire

/* tb/pid_integral_separation_top_tb.sv */
`timescale 1ns / 1ps
module pid_integral_separation_top_tb;
  import pis_pkg::*;

  localparam int          LIMIT_CYCLES = 600000;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam longint      DERIV_CAP = 64'sh1000_0000_0000_0000;

  typedef enum int {SET_MAX, SET_MIN, SET_RANDOM} setting_mode_e;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     integrating;
  } drive_rec_t;

  class drive_tracker;
    longint     prop_gain, integ_gain, deriv_gain;
    longint     rate_hz, out_limit, int_limit, band_width;
    longint     filt_meas, integ_acc;
    drive_rec_t drive_queue[$];
    int         failures;

    function new();
      prop_gain  = 0;
      integ_gain = 0;
      deriv_gain = 0;
      rate_hz    = 1000;
      out_limit  = 64'h7FFF_FFFF;
      int_limit  = 64'h7FFF_FFFF;
      band_width = 0;
      filt_meas  = 0;
      integ_acc  = 0;
      failures   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:  prop_gain  = longint'($signed(data));
        REG_INTEG_GAIN: integ_gain = longint'($signed(data));
        REG_DERIV_GAIN: deriv_gain = longint'($signed(data));
        REG_RATE:       rate_hz    = longint'(data[RATE_W-1:0]);
        REG_OUT_LIMIT:  out_limit  = longint'(data[LIM_W-1:0]);
        REG_INT_LIMIT:  int_limit  = longint'(data[LIM_W-1:0]);
        REG_SEP_BAND:   band_width = longint'(data[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    // Advance the filter and integrator by one request and queue its drive.
    function void note_sample(logic signed [DATA_W-1:0] meas,
                              logic signed [DATA_W-1:0] sp,
                              logic signed [DATA_W-1:0] ff);
      longint     m, s, f, rate, prev, err, aerr, fsum;
      longint     p, prod, inc, t, tmag, d, tot;
      bit         band;
      drive_rec_t rec;
      m    = meas;
      s    = sp;
      f    = ff;
      rate = (rate_hz == 0) ? 1 : rate_hz;
      prev = filt_meas;
      err  = s - m;
      aerr = (err < 0) ? -err : err;

      fsum = 4 * prev + m;
      filt_meas = (fsum >= 0) ? fsum / 5 : -((-fsum + 4) / 5);

      p = (prop_gain * err) >>> FRAC_BITS;

      band = aerr < band_width;
      if (band) begin
        prod = integ_gain * err;
        inc  = prod / (rate * 65536);
        integ_acc = clamp_sym(integ_acc + inc, int_limit);
      end else begin
        integ_acc = 0;
      end

      t    = (deriv_gain * (m - prev)) >>> FRAC_BITS;
      tmag = (t < 0) ? -t : t;
      if (tmag > DERIV_CAP / rate) d = (t < 0) ? -DERIV_CAP : DERIV_CAP;
      else d = t * rate;

      f   = clamp_sym(f, out_limit);
      tot = clamp_sym(p + (band ? integ_acc : 0) + d + f, out_limit);

      rec.drive       = tot[DATA_W-1:0];
      rec.integrating = band;
      drive_queue.push_back(rec);
    endfunction

    function void check_drive(logic signed [DATA_W-1:0] drive, logic integrating);
      drive_rec_t exp_rec;
      if (drive_queue.size() == 0) begin
        $error("unexpected result: drive %0d integrating %0b", drive, integrating);
        failures++;
        return;
      end
      exp_rec = drive_queue.pop_front();
      if (drive !== exp_rec.drive) begin
        $error("drive: expected %0d, got %0d", exp_rec.drive, drive);
        failures++;
      end
      if (integrating !== exp_rec.integrating) begin
        $error("integrating: expected %0b, got %0b", exp_rec.integrating, integrating);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;

  pis_in_if  in_ch();
  pis_out_if out_ch();

  drive_tracker tracker = new();

  logic [DATA_W-1:0] reg_words [0:REG_SEP_BAND];
  logic [DATA_W-1:0] target;
  bit                calm;
  bit                hold_long;
  int                cycle_count;

  pid_integral_separation_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("pid_integral_separation_top_tb failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = calm ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.check_drive(out_ch.drive, out_ch.integrating);
    end
  end

  task automatic apply_settings();
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    junk;
    for (int i = 0; i <= REG_SEP_BAND; i++) begin
      idx = i;
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= reg_words[i];
      @(posedge clk);
      tracker.set_reg(idx, reg_words[i]);
    end
    // a write past the last register must change nothing
    junk = $urandom;
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    tracker.set_reg(REG_UNUSED, junk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return '0;
      3: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 32'h0100_0000);
      4: return Q_MAX;
      default: return {$urandom_range(0, 1) == 1, 31'd0};
    endcase
  endfunction

  task automatic choose_settings(setting_mode_e mode);
    logic [RATE_W-1:0] rate;
    case (mode)
      SET_MAX: begin
        reg_words[REG_PROP_GAIN]  = Q_MAX;
        reg_words[REG_INTEG_GAIN] = Q_MAX;
        reg_words[REG_DERIV_GAIN] = Q_MAX;
        reg_words[REG_RATE]       = 32'h0000_FFFF;
        reg_words[REG_OUT_LIMIT]  = Q_MAX;
        reg_words[REG_INT_LIMIT]  = Q_MAX;
        reg_words[REG_SEP_BAND]   = Q_MAX;
      end
      SET_MIN: begin
        // zero rate counts as one; zero limits force drive and integrator to zero
        reg_words[REG_PROP_GAIN]  = Q_MIN;
        reg_words[REG_INTEG_GAIN] = Q_MIN;
        reg_words[REG_DERIV_GAIN] = Q_MIN;
        reg_words[REG_RATE]       = 32'hFFFF_0000;
        reg_words[REG_OUT_LIMIT]  = 32'h8000_0000;
        reg_words[REG_INT_LIMIT]  = '0;
        reg_words[REG_SEP_BAND]   = '0;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: rate = 1;
          1: rate = $urandom_range(1, 100);
          2: rate = $urandom_range(1, 65535);
          default: rate = 1000;
        endcase
        reg_words[REG_PROP_GAIN]  = pick_gain();
        reg_words[REG_INTEG_GAIN] = pick_gain();
        reg_words[REG_DERIV_GAIN] = pick_gain();
        reg_words[REG_RATE]       = {16'($urandom), rate};
        reg_words[REG_OUT_LIMIT]  = pick_limit();
        reg_words[REG_INT_LIMIT]  = pick_limit();
        case ($urandom_range(0, 3))
          0: reg_words[REG_SEP_BAND] = $urandom_range(0, 32'h0004_0000);
          1: reg_words[REG_SEP_BAND] = $urandom_range(0, 32'h0100_0000);
          2: reg_words[REG_SEP_BAND] = $urandom;
          default: reg_words[REG_SEP_BAND] = Q_MAX;
        endcase
      end
    endcase
  endtask

  task automatic offer(logic [DATA_W-1:0] m, logic [DATA_W-1:0] s, logic [DATA_W-1:0] f);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.measured    <= m;
    in_ch.setpoint    <= s;
    in_ch.feedforward <= f;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_sample(m, s, f);
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.drive_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly track a slowly moving target with errors near the band edge.
  task automatic send_random_sample();
    logic [DATA_W-1:0] m, s, f;
    longint            band, span, e;
    band = reg_words[REG_SEP_BAND][LIM_W-1:0];
    if ($urandom_range(0, 19) == 0)
      target = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    if ($urandom_range(0, 9) < 7) begin
      span = band + band / 2 + 1;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      e = longint'($urandom_range(0, 32'(2 * span))) - span;
      s = target + ($urandom_range(0, 32'h0000_2000) - 32'h0000_1000);
      m = s - e[DATA_W-1:0];
    end else begin
      m = $urandom;
      s = $urandom;
    end
    if ($urandom_range(0, 3) == 0) f = $urandom;
    else f = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    offer(m, s, f);
  endtask

  initial begin
    int n_items;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_PROP_GAIN;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.measured    <= '0;
    in_ch.setpoint    <= '0;
    in_ch.feedforward <= '0;
    calm      = 1'b0;
    hold_long = 1'b0;
    target    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: zero gains, feedforward only
    offer('0, '0, '0);
    offer('0, '0, Q_MAX);
    offer('0, '0, Q_MIN);
    offer(Q_MIN, Q_MAX, '0);
    drain();

    reg_words[REG_PROP_GAIN]  = Q_ONE;
    reg_words[REG_INTEG_GAIN] = Q_ONE * 4;
    reg_words[REG_DERIV_GAIN] = Q_ONE / 2;
    reg_words[REG_RATE]       = 1;
    reg_words[REG_OUT_LIMIT]  = Q_ONE * 100;
    reg_words[REG_INT_LIMIT]  = Q_ONE * 5;
    reg_words[REG_SEP_BAND]   = Q_ONE * 2;
    apply_settings();
    // integrate up to the clamp, hit the band edge, then integrate negative
    offer('0, Q_ONE, '0);
    offer('0, Q_ONE, '0);
    offer('0, Q_ONE, '0);
    offer('0, Q_ONE * 2, '0);
    offer('0, -Q_ONE, '0);
    offer('0, -(Q_ONE + Q_ONE / 2), '0);
    offer(Q_MAX, Q_MIN, Q_MAX);
    offer(Q_MIN, Q_MAX, Q_MIN);
    offer(Q_ONE * 50, Q_ONE * 50, Q_ONE * 200);
    drain();

    choose_settings(SET_MAX);
    apply_settings();
    offer(Q_MIN, Q_MAX, '0);
    offer(Q_MAX, Q_MIN, '0);
    offer('0, '0, '0);
    offer(Q_ONE, Q_ONE + 1, Q_MIN);
    drain();

    choose_settings(SET_MIN);
    apply_settings();
    offer(Q_MIN, Q_MAX, Q_MAX);
    offer(Q_MAX, Q_MIN, Q_MIN);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) choose_settings(SET_MAX);
      else if (phase == 1) choose_settings(SET_MIN);
      else choose_settings(SET_RANDOM);
      apply_settings();
      calm = (phase % 3 == 1);
      n_items = (phase < 2) ? 60 : 185;
      for (int k = 0; k < n_items; k++) begin
        // stall the result side long enough to back up the input
        if (phase == 3 && k == 20) hold_long = 1'b1;
        if (phase == 5 && k == 90) drain();
        send_random_sample();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (tracker.failures == 0 && tracker.drive_queue.size() == 0) begin
      $display("pid_integral_separation_top_tb passed");
    end else begin
      $display("pid_integral_separation_top_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pis_pkg.sv
rtl/pis_if.sv
rtl/pid_integral_separation_top.sv
rtl/pis_checker.sv
tb/pid_integral_separation_top_tb.sv
